[src/qts_pkg.sv]
// ----------------------------------------------------------------------------
// qts_pkg
// Types and character constants shared by the quoted token scanner.
// ----------------------------------------------------------------------------
package qts_pkg;

  // Result kinds on the output channel.
  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_END      = 2'd1,
    KIND_TEXT_END = 2'd2
  } kind_e;

  // Scanner modes, one-hot.
  typedef enum logic [4:0] {
    MODE_SKIP    = 5'b00001,
    MODE_SLASH   = 5'b00010,
    MODE_COMMENT = 5'b00100,
    MODE_QUOTE   = 5'b01000,
    MODE_WORD    = 5'b10000
  } mode_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Result queue between the classifier and the output sequencer.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_value;
    logic [7:0] token_length;
    logic       discarded;
    logic       was_quoted;
  } res_t;

  // All results caused by one input byte (num is 1 to 3).
  typedef struct packed {
    logic [1:0]     num;
    res_t [2:0]     res;
  } qent_t;

endpackage

[src/qts_front.sv]
// ----------------------------------------------------------------------------
// qts_front
// Accepts text bytes, tracks the scanner mode and token count, and bundles
// the results of each byte into one queue entry.
// ----------------------------------------------------------------------------
module qts_front #(
  parameter int unsigned MAX_TOKEN_LEN = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    text_byte_i,
  input  logic          q_full_i,
  output logic          push_o,
  output qts_pkg::qent_t push_ent_o
);
  import qts_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_TOKEN_LEN);

  mode_e           mode_q, mode_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            quo_q, quo_d;

  logic            accept;
  logic            word_ch;
  logic            wk;
  logic [CntW-1:0] wcnt;
  logic [1:0]      num;
  res_t [2:0]      res_c;

  function automatic res_t mk_char(logic [7:0] ch, logic quoted);
    res_t r;
    r            = '0;
    r.kind       = KIND_CHAR;
    r.char_value = ch;
    r.was_quoted = quoted;
    return r;
  endfunction

  function automatic res_t mk_end(logic [CntW-1:0] cnt, logic quoted);
    res_t            r;
    logic [CntW+7:0] wide;
    r            = '0;
    wide         = {8'd0, cnt};
    r.kind       = KIND_END;
    r.discarded  = (cnt >= MaxCnt);
    r.token_length = r.discarded ? 8'd0 : wide[7:0];
    r.was_quoted = quoted;
    return r;
  endfunction

  function automatic res_t mk_text_end();
    res_t r;
    r      = '0;
    r.kind = KIND_TEXT_END;
    return r;
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign word_ch    = (text_byte_i > CH_SPACE) && !text_byte_i[7];

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    num    = 2'd0;
    res_c  = '0;
    wk     = 1'b0;
    wcnt   = cnt_q;
    case (mode_q)
      MODE_SLASH: begin
        if (text_byte_i == CH_SLASH) begin
          mode_d = MODE_COMMENT;
        end else begin
          // The held slash opens a word; this byte then continues it or ends it.
          res_c[0] = mk_char(CH_SLASH, 1'b0);
          num      = 2'd1;
          wk       = 1'b1;
          wcnt     = CntW'(1);
        end
      end
      MODE_COMMENT: begin
        if (text_byte_i == CH_NUL) begin
          res_c[0] = mk_text_end();
          num      = 2'd1;
          mode_d   = MODE_SKIP;
          cnt_d    = '0;
          quo_d    = 1'b0;
        end else if (text_byte_i == CH_NL) begin
          mode_d = MODE_SKIP;
        end
      end
      MODE_QUOTE: begin
        if (text_byte_i == CH_QUOTE || text_byte_i == CH_NUL) begin
          res_c[0] = mk_end(cnt_q, quo_q);
          num      = 2'd1;
          if (text_byte_i == CH_NUL) begin
            res_c[1] = mk_text_end();
            num      = 2'd2;
          end
          mode_d = MODE_SKIP;
          cnt_d  = '0;
          quo_d  = 1'b0;
        end else if (cnt_q < MaxCnt) begin
          res_c[0] = mk_char(text_byte_i, quo_q);
          num      = 2'd1;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      MODE_WORD: begin
        wk = 1'b1;
      end
      default: begin
        mode_d = MODE_SKIP;
        if (text_byte_i == CH_NUL) begin
          res_c[0] = mk_text_end();
          num      = 2'd1;
          cnt_d    = '0;
          quo_d    = 1'b0;
        end else if (!word_ch) begin
          mode_d = MODE_SKIP;
        end else if (text_byte_i == CH_QUOTE) begin
          mode_d = MODE_QUOTE;
          cnt_d  = '0;
          quo_d  = 1'b1;
        end else if (text_byte_i == CH_SLASH) begin
          mode_d = MODE_SLASH;
        end else begin
          res_c[0] = mk_char(text_byte_i, 1'b0);
          num      = 2'd1;
          mode_d   = MODE_WORD;
          cnt_d    = CntW'(1);
          quo_d    = 1'b0;
        end
      end
    endcase

    if (wk) begin
      if (word_ch) begin
        mode_d = MODE_WORD;
        quo_d  = 1'b0;
        cnt_d  = wcnt;
        if (wcnt < MaxCnt) begin
          res_c[num] = mk_char(text_byte_i, 1'b0);
          num        = num + 2'd1;
          cnt_d      = wcnt + 1'b1;
        end
      end else begin
        res_c[num] = mk_end(wcnt, 1'b0);
        num        = num + 2'd1;
        if (text_byte_i == CH_NUL) begin
          res_c[num] = mk_text_end();
          num        = num + 2'd1;
        end
        mode_d = MODE_SKIP;
        cnt_d  = '0;
        quo_d  = 1'b0;
      end
    end
  end

  assign push_o         = accept && (num != 2'd0);
  assign push_ent_o.num = num;
  assign push_ent_o.res = res_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SKIP;
      cnt_q  <= '0;
      quo_q  <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      quo_q  <= quo_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("token count above maximum");

  a_quote_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quo_q |-> mode_q == MODE_QUOTE)
    else $error("quoted flag set outside a quoted string");

endmodule

[src/qts_queue.sv]
// ----------------------------------------------------------------------------
// qts_queue
// Short register queue of per-byte result bundles.
// ----------------------------------------------------------------------------
module qts_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  qts_pkg::qent_t push_ent_i,
  input  logic           pop_i,
  output qts_pkg::qent_t head_o,
  output logic           empty_o,
  output logic           full_o
);
  import qts_pkg::*;

  qent_t            ent_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign head_o  = ent_q[rd_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q < QCntW'(QDepth))
    else $error("push into a full result queue");

endmodule

[src/qts_back.sv]
// ----------------------------------------------------------------------------
// qts_back
// Walks the results of the head queue entry, one per cycle while the output
// is not stalled, into the output register.
// ----------------------------------------------------------------------------
module qts_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qts_pkg::qent_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     kind_o,
  output logic           last_o,
  output logic [7:0]     char_value_o,
  output logic [7:0]     token_length_o,
  output logic           discarded_o,
  output logic           was_quoted_o
);
  import qts_pkg::*;

  logic [1:0] pos_q;
  logic       out_valid_q;
  res_t       out_res_q;
  logic       out_last_q;
  logic       load;
  logic       is_last;

  assign load    = !empty_i && (!out_valid_q || !out_stall_i);
  assign is_last = (pos_q == head_i.num - 2'd1);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        pos_q       <= is_last ? 2'd0 : pos_q + 2'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_res_q  <= head_i.res[pos_q];
      out_last_q <= is_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_res_q.kind;
  assign last_o         = out_last_q;
  assign char_value_o   = out_res_q.char_value;
  assign token_length_o = out_res_q.token_length;
  assign discarded_o    = out_res_q.discarded;
  assign was_quoted_o   = out_res_q.was_quoted;

  a_pos_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> pos_q < head_i.num)
    else $error("result index past the end of its entry");

  a_text_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.kind == KIND_TEXT_END) |-> out_last_q)
    else $error("end of text is not the last result of its byte");

endmodule

[src/quoted_token_scanner_unit.sv]
// ----------------------------------------------------------------------------
// quoted_token_scanner_unit
// Splits a byte stream into whitespace-separated words and quoted strings,
// skipping line comments, and emits token characters and token ends.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i/in_stall_o   text_byte_i
//  out      output     out_valid_o/out_stall_i kind_o, last_o, char_value_o,
//                                              token_length_o, discarded_o,
//                                              was_quoted_o
//
// A byte is classified in the cycle it is accepted; its one to three
// results enter a four-entry queue as one bundle.
// The output sequencer sends one result per cycle from the queue head while
// the output is not stalled, so a byte with one result sustains one byte per
// cycle; a byte with k results passes them out one after another.
// A byte's results pass through the queue and then the output register.
// in_stall_o rises only when the queue is full. Reset clears mode, count,
// queue pointers and the output valid.
// ----------------------------------------------------------------------------
module quoted_token_scanner_unit #(
  parameter int unsigned MAX_TOKEN_LEN = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic       last_o,
  output logic [7:0] char_value_o,
  output logic [7:0] token_length_o,
  output logic       discarded_o,
  output logic       was_quoted_o
);
  import qts_pkg::*;

  logic  push;
  qent_t push_ent;
  logic  pop;
  qent_t head;
  logic  q_empty;
  logic  q_full;

  qts_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .text_byte_i(text_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_ent_o (push_ent)
  );

  qts_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_ent_i(push_ent),
    .pop_i     (pop),
    .head_o    (head),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  qts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .last_o        (last_o),
    .char_value_o  (char_value_o),
    .token_length_o(token_length_o),
    .discarded_o   (discarded_o),
    .was_quoted_o  (was_quoted_o)
  );

endmodule

[verif/qts_checker.sv]
// ----------------------------------------------------------------------------
// qts_checker
// Watches both channels of the quoted token scanner. A predictor tracks the
// scan mode, the kept-character count and the quote flag for every accepted
// byte, queues the results it expects, and compares each result on the
// output channel with the oldest one. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module qts_checker #(
  parameter int unsigned MAX_TOKEN_LEN = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  text_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic        last_i,
  input  logic [7:0]  char_value_i,
  input  logic [7:0]  token_length_i,
  input  logic        discarded_i,
  input  logic        was_quoted_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import qts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] kind;
    logic       last;
    logic [7:0] char_value;
    logic [7:0] token_length;
    logic       discarded;
    logic       was_quoted;
  } scan_result_t;

  scan_result_t expected_results[$];

  mode_e       scan_mode;
  int unsigned kept_chars;
  logic        quoted_token;

  function automatic void push_result(logic [1:0] kind, logic [7:0] ch, logic [7:0] len,
                                      logic disc, logic quoted);
    scan_result_t r;
    r.kind         = kind;
    r.last         = 1'b0;
    r.char_value   = ch;
    r.token_length = len;
    r.discarded    = disc;
    r.was_quoted   = quoted;
    expected_results.push_back(r);
  endfunction

  // Characters past the maximum length are dropped silently.
  function automatic void keep_char(logic [7:0] ch);
    if (kept_chars < MAX_TOKEN_LEN) begin
      push_result(KIND_CHAR, ch, 8'd0, 1'b0, quoted_token);
      kept_chars++;
    end
  endfunction

  function automatic void close_token();
    logic disc;
    disc = (kept_chars >= MAX_TOKEN_LEN);
    push_result(KIND_END, 8'd0, disc ? 8'd0 : kept_chars[7:0], disc, quoted_token);
    kept_chars   = 0;
    quoted_token = 1'b0;
    scan_mode    = MODE_SKIP;
  endfunction

  function automatic void close_text();
    push_result(KIND_TEXT_END, 8'd0, 8'd0, 1'b0, 1'b0);
    kept_chars   = 0;
    quoted_token = 1'b0;
    scan_mode    = MODE_SKIP;
  endfunction

  function automatic void open_token(logic quoted, mode_e mode);
    kept_chars   = 0;
    quoted_token = quoted;
    scan_mode    = mode;
  endfunction

  function automatic void word_step(logic [7:0] b);
    if (b > CH_SPACE && b < 8'h80) begin
      keep_char(b);
    end else begin
      close_token();
      if (b == CH_NUL) close_text();
    end
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    int unsigned before_count;
    before_count = expected_results.size();
    case (scan_mode)
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          scan_mode = MODE_COMMENT;
        end else begin
          open_token(1'b0, MODE_WORD);
          keep_char(CH_SLASH);
          word_step(b);
        end
      end
      MODE_COMMENT: begin
        if (b == CH_NUL) close_text();
        else if (b == CH_NL) scan_mode = MODE_SKIP;
      end
      MODE_QUOTE: begin
        if (b == CH_QUOTE) begin
          close_token();
        end else if (b == CH_NUL) begin
          close_token();
          close_text();
        end else begin
          keep_char(b);
        end
      end
      MODE_WORD: word_step(b);
      default: begin
        if (b == CH_NUL) close_text();
        else if (b <= CH_SPACE || b >= 8'h80) scan_mode = MODE_SKIP;
        else if (b == CH_QUOTE) open_token(1'b1, MODE_QUOTE);
        else if (b == CH_SLASH) scan_mode = MODE_SLASH;
        else begin
          open_token(1'b0, MODE_WORD);
          keep_char(b);
        end
      end
    endcase
    if (expected_results.size() > before_count)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scan_result_t seen;
    scan_result_t want;
    if (!rst_ni) begin
      scan_mode    = MODE_SKIP;
      kept_chars   = 0;
      quoted_token = 1'b0;
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen = '{kind_i, last_i, char_value_i, token_length_i, discarded_i, was_quoted_i};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d last=%0d char=%h len=%0d disc=%0d quoted=%0d",
                   $time, seen.kind, seen.last, seen.char_value, seen.token_length,
                   seen.discarded, seen.was_quoted);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            $display("%0t: mismatch expected kind=%0d last=%0d char=%h len=%0d disc=%0d quoted=%0d",
                     $time, want.kind, want.last, want.char_value, want.token_length,
                     want.discarded, want.was_quoted);
            $display("%0t:          actual   kind=%0d last=%0d char=%h len=%0d disc=%0d quoted=%0d",
                     $time, seen.kind, seen.last, seen.char_value, seen.token_length,
                     seen.discarded, seen.was_quoted);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) scan_byte(text_byte_i);
    end
    pending_o = expected_results.size();
  end

endmodule

[verif/tb_quoted_token_scanner_unit.sv]
// ----------------------------------------------------------------------------
// tb_quoted_token_scanner_unit
// Drives text into the quoted token scanner: a short directed opening that
// hits words, quoted strings, comments, lone slashes, NUL bytes and high
// bytes, then random well-formed text with some noise. Both channels idle in
// random bursts except for bytes 150 to 199 and from byte 300 on. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_quoted_token_scanner_unit;
  import qts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxTokenLen    = 128;
  localparam int unsigned RandomBytes    = 334;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned DrainCycles    = 8;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  text_byte_i = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic        last_o;
  logic [7:0]  char_value_o;
  logic [7:0]  token_length_o;
  logic        discarded_o;
  logic        was_quoted_o;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned bytes_sent  = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  logic        idling_on   = 1'b1;

  always #5 clk_i = ~clk_i;

  quoted_token_scanner_unit #(.MAX_TOKEN_LEN(MaxTokenLen)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .text_byte_i,
    .out_valid_o, .out_stall_i, .kind_o, .last_o, .char_value_o,
    .token_length_o, .discarded_o, .was_quoted_o
  );

  qts_checker #(.MAX_TOKEN_LEN(MaxTokenLen)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .text_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i, .kind_i(kind_o), .last_i(last_o),
    .char_value_i(char_value_o), .token_length_i(token_length_o),
    .discarded_i(discarded_o), .was_quoted_i(was_quoted_o),
    .fail_count_o(fail_count), .pending_o(pending_results)
  );

  // Receiver back-pressure in bursts of random length.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 14);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Called and returns at a falling edge; holds the byte until accepted.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    idling_on = (bytes_sent < 150) || (bytes_sent >= 200 && bytes_sent < 300);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] blank_byte();
    return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 32)) : 8'($urandom_range(128, 255));
  endfunction

  task automatic send_segment();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  b;
    pick = $urandom_range(0, 15);
    len  = ($urandom_range(0, 30) == 0) ? $urandom_range(120, 135) : $urandom_range(0, 8);
    if (pick <= 4) begin
      // A plain word must not start with a quote or a slash.
      b = 8'($urandom_range(8'h21, 8'h7F));
      if (b == CH_QUOTE || b == CH_SLASH) b = "w";
      send_byte(b);
      repeat (len) send_byte(8'($urandom_range(8'h21, 8'h7F)));
      send_byte(($urandom_range(0, 9) == 0) ? CH_NUL : blank_byte());
    end else if (pick <= 7) begin
      send_byte(CH_QUOTE);
      repeat (len) begin
        b = 8'($urandom_range(1, 255));
        send_byte((b == CH_QUOTE) ? CH_NL : b);
      end
      send_byte(($urandom_range(0, 9) == 0) ? CH_NUL : CH_QUOTE);
    end else if (pick <= 9) begin
      send_byte(CH_SLASH);
      send_byte(CH_SLASH);
      repeat (len) begin
        b = 8'($urandom_range(1, 255));
        send_byte((b == CH_NL) ? CH_SPACE : b);
      end
      send_byte(($urandom_range(0, 9) == 0) ? CH_NUL : CH_NL);
    end else if (pick == 10) begin
      send_byte(CH_SLASH);
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick == 11) begin
      send_byte(CH_NUL);
    end else if (pick <= 13) begin
      repeat ($urandom_range(1, 3)) send_byte(blank_byte());
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [7:0] opening_text[$];
    opening_text = '{
      "a", "b", 8'h7F, CH_SPACE,                       // word ended by a space
      CH_QUOTE, CH_QUOTE,                              // empty quoted string
      CH_QUOTE, 8'hFF, 8'h01, CH_QUOTE, "w", 8'h80,    // word right after a quote
      CH_SLASH, "x", CH_NL,                            // lone slash starts a word
      CH_SLASH, CH_SLASH, "c", CH_NUL,                 // NUL inside a comment
      CH_SLASH, CH_NUL,                                // slash, token end, text end
      CH_QUOTE, "q", CH_NUL,                           // NUL inside a quote
      "z", CH_NUL                                      // NUL inside a word
    };
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (opening_text[i]) send_byte(opening_text[i]);
    while (bytes_sent < opening_text.size() + RandomBytes) send_segment();
    in_valid_i <= 1'b0;
    while (pending_results != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[quoted_token_scanner_unit.f]
src/qts_pkg.sv
src/qts_front.sv
src/qts_queue.sv
src/qts_back.sv
src/quoted_token_scanner_unit.sv
verif/qts_checker.sv
verif/tb_quoted_token_scanner_unit.sv
